@@ design/gapr_pkg.sv @@
// Shared types and constants for the gravity-aligned point rotation block.
`timescale 1ns / 1ps
`default_nettype none
package gapr_pkg;

    localparam int COORD_W   = 32;
    localparam int ACCEL_W   = 16;
    localparam int QFRAC     = 14;
    localparam int QUAT_W    = 16;
    localparam int GUARD     = 30 - ACCEL_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACCEL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_LIMIT = 1'b1;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_IDENT  = 2'd1;
    localparam logic [1:0] ST_FLIP   = 2'd2;

    // reset values kept as squares: min magnitude 1, flip limit 16368
    localparam logic [31:0] MIN_SQ_RST  = 32'd1;
    localparam logic [29:0] FLIP_SQ_RST = 30'd267911424;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic signed [COORD_W-1:0] rotated_z;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_i;
        logic signed [QUAT_W-1:0]  quat_j;
        logic signed [QUAT_W-1:0]  quat_k;
        logic [1:0]                align_status;
    } t_out;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_sqrt;

endpackage
`default_nettype wire

@@ design/gapr_sqrt_cell.sv @@
// One step of the digit-by-digit integer square root chain.
`timescale 1ns / 1ps
`default_nettype none
module gapr_sqrt_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  gapr_pkg::t_sqrt      i_data,
    input  wire [SIDE_W-1:0]     i_side,
    output logic                 o_valid,
    output gapr_pkg::t_sqrt      o_data,
    output logic [SIDE_W-1:0]    o_side
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic            r_valid;
    gapr_pkg::t_sqrt r_data;
    logic [SIDE_W-1:0] r_side;
    logic [63:0]     trial;
    logic            take;
    gapr_pkg::t_sqrt n_data;

    always_comb begin
        trial = i_data.root + BIT;
        take  = i_data.rem >= trial;
        n_data.rem  = take ? i_data.rem - trial : i_data.rem;
        n_data.root = take ? (i_data.root >> 1) + BIT : i_data.root >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule
`default_nettype wire

@@ design/gapr_div_cell.sv @@
// One quotient bit of the three-lane restoring divider chain.
`timescale 1ns / 1ps
`default_nettype none
module gapr_div_cell #(
    parameter int STEP   = 0,
    parameter int FB     = 14,
    parameter int SIDE_W = 1
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  wire [31:0]            i_div,
    input  wire [2:0][32:0]       i_rem,
    input  wire [2:0][FB:0]       i_low,
    input  wire [2:0][FB:0]       i_quo,
    input  wire [SIDE_W-1:0]      i_side,
    output logic                  o_valid,
    output logic [31:0]           o_div,
    output logic [2:0][32:0]      o_rem,
    output logic [2:0][FB:0]      o_low,
    output logic [2:0][FB:0]      o_quo,
    output logic [SIDE_W-1:0]     o_side
);

    logic              r_valid;
    logic [31:0]       r_div;
    logic [2:0][32:0]  r_rem;
    logic [2:0][FB:0]  r_low;
    logic [2:0][FB:0]  r_quo;
    logic [SIDE_W-1:0] r_side;
    logic [2:0][32:0]  n_rem;
    logic [2:0][FB:0]  n_quo;
    logic [2:0][32:0]  sh;
    logic [2:0]        take;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sh[l]    = {i_rem[l][31:0], i_low[l][FB-STEP]};
            take[l]  = sh[l] >= {1'b0, i_div};
            n_rem[l] = take[l] ? sh[l] - {1'b0, i_div} : sh[l];
            n_quo[l] = i_quo[l] | ((FB + 1)'(take[l]) << (FB - STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            r_rem  <= n_rem;
            r_low  <= i_low;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule
`default_nettype wire

@@ design/gravity_align_point_rotation.sv @@
// Top level: gravity-aligned quaternion build and point rotation pipeline.
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data) takes one point with its
//   accelerometer sample per beat. Output channel (o_out_valid/i_out_ready/
//   o_out_data) returns the rotated point, the quaternion and the status.
//   Config channel (i_cfg_valid/o_cfg_ready) writes min_accel_magnitude
//   (index 0) and flip_limit (index 1); always ready, write only when idle.
//   Throughput: one beat per cycle while the receiver does not stall. The
//   delay from input to output is set by two 32-cell square root chains,
//   a 15-cell divider chain and the rotation stages.
//   Reset clears all valid bits and loads the register defaults; the block
//   takes input in the first cycle after reset.
//   When the receiver stalls, the whole pipeline holds; a skid register on
//   the input still takes one more beat, after which o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module gravity_align_point_rotation (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  gapr_pkg::t_in                         i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output gapr_pkg::t_out                        o_out_data,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [gapr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [gapr_pkg::CFG_DAT_W-1:0]         i_cfg_data
);

    localparam int CW   = gapr_pkg::COORD_W;
    localparam int AW   = gapr_pkg::ACCEL_W;
    localparam int F    = gapr_pkg::QFRAC;
    localparam int G    = gapr_pkg::GUARD;
    localparam int A2   = 2 * AW;
    localparam int M2W  = A2 + 2;
    localparam int LW   = A2 + 28;
    localparam int RHW  = 30 + M2W;
    localparam int CMPW = (LW > RHW) ? LW : RHW;
    localparam int DW   = 33 + F;
    localparam int QW2  = F + 2;
    localparam int QP   = 2 * QW2;
    localparam int RW   = QP + 2;
    localparam int PW   = RW + CW;
    localparam int AW2  = PW + 2;
    localparam int NSQ  = 32;
    localparam int NDIV = F + 1;

    localparam logic signed [QW2-1:0] Q_ONE   = QW2'(1) << F;
    localparam logic signed [AW2-1:0] HALF    = AW2'(1) << (2 * F - 1);
    localparam logic [CW-1:0]         SAT_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0]         SAT_MIN = {1'b1, {(CW - 1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_pt;

    typedef struct packed {
        logic [1:0]     st;
        gapr_pkg::t_in  d;
    } t_side1;

    typedef struct packed {
        logic [1:0]  st;
        logic        sx;
        logic        sz;
        logic [31:0] w;
        logic [31:0] xm;
        logic [31:0] zm;
        t_pt         pt;
    } t_side2;

    typedef struct packed {
        logic [1:0] st;
        logic       sx;
        logic       sz;
        t_pt        pt;
    } t_side3;

    localparam int S1W = $bits(t_side1);
    localparam int S2W = $bits(t_side2);
    localparam int S3W = $bits(t_side3);

    // configuration, kept as squares
    logic [31:0] r_min_sq;
    logic [29:0] r_flip_sq;

    logic en;
    logic r_skid_v;
    gapr_pkg::t_in r_skid_d;
    logic src_v;
    gapr_pkg::t_in src_d;

    logic r1_v, r2_v, r3_v, r4_v, r6_v, r7_v, r8_v, r9_v;
    logic r10_v, r11_v, r12_v, r13_v, r14_v, r_o_v;

    gapr_pkg::t_in r1_d, r2_d, r3_d, r4_d;
    logic [A2-1:0]  r2_sqx, r2_sqy, r2_sqz, n2_sqx, n2_sqy, n2_sqz;
    logic [M2W-1:0] r3_m2, r4_m2;
    logic [A2-1:0]  r3_ay2;
    logic           r4_weak;
    logic [LW-1:0]  r4_lhs;
    logic [RHW-1:0] r4_rhs;
    logic           flip;
    logic [1:0]     st4;

    logic             c1_v [0:NSQ];
    gapr_pkg::t_sqrt  c1_d [0:NSQ];
    logic [S1W-1:0]   c1_s [0:NSQ];
    t_side1           s1o;

    logic [31:0]             n_root1;
    logic signed [32:0]      ayg, w33;
    logic signed [AW:0]      ax_e, az_e, ax_abs, az_abs;
    logic [1:0]              r6_st, r7_st, r8_st;
    t_pt                     r6_pt, r7_pt, r8_pt;
    logic [31:0]             r6_w, r6_xm, r6_zm, r7_w, r7_xm, r7_zm, r8_w, r8_xm, r8_zm;
    logic                    r6_sx, r6_sz, r7_sx, r7_sz, r8_sx, r8_sz;
    logic [63:0]             r7_w2, r7_x2, r7_z2, r8_sum;
    t_side2                  s2i, s2o;

    logic             c2_v [0:NSQ];
    gapr_pkg::t_sqrt  c2_d [0:NSQ];
    logic [S2W-1:0]   c2_s [0:NSQ];

    logic [31:0]         qn;
    logic [2:0][DW-1:0]  r9_dd;
    logic [31:0]         r9_div;
    t_side3              r9_side;

    logic            c3_v   [0:NDIV];
    logic [31:0]     c3_div [0:NDIV];
    logic [2:0][32:0] c3_rem [0:NDIV];
    logic [2:0][F:0] c3_low [0:NDIV];
    logic [2:0][F:0] c3_quo [0:NDIV];
    logic [S3W-1:0]  c3_s   [0:NDIV];
    t_side3          s3o;

    logic signed [QW2-1:0] ew, ex, ez, n10_qw, n10_qx, n10_qz;
    logic signed [QW2-1:0] r10_qw, r10_qx, r10_qz, r11_qw, r11_qx, r11_qz;
    logic signed [QW2-1:0] r12_qw, r12_qx, r12_qz, r13_qw, r13_qx, r13_qz;
    logic signed [QW2-1:0] r14_qw, r14_qx, r14_qz;
    logic [1:0]  r10_st, r11_st, r12_st, r13_st, r14_st;
    t_pt         r10_pt, r11_pt, r12_pt;
    logic signed [QP-1:0] r11_ww, r11_xx, r11_zz, r11_wz, r11_wx, r11_xz;
    logic signed [RW-1:0] r12_m [9];
    logic signed [PW-1:0] r13_p [9];
    logic signed [AW2-1:0] r14_acc [3];
    logic signed [AW2-1:0] n_sh [3];
    logic [CW-1:0]         n_rot [3];
    gapr_pkg::t_out        r_o_d;

    // -------- config --------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sq  <= gapr_pkg::MIN_SQ_RST;
            r_flip_sq <= gapr_pkg::FLIP_SQ_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gapr_pkg::CFG_MIN_ACCEL: begin
                    r_min_sq <= i_cfg_data * i_cfg_data;
                end
                gapr_pkg::CFG_FLIP_LIMIT: begin
                    r_flip_sq <= i_cfg_data[14:0] * i_cfg_data[14:0];
                end
            endcase
        end
    end

    // -------- input skid and global advance --------
    assign en         = !r_o_v || i_out_ready;
    assign o_in_ready = !r_skid_v;
    assign src_v      = r_skid_v || i_in_valid;
    assign src_d      = r_skid_v ? r_skid_d : i_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end else if (i_in_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && i_in_valid && !r_skid_v) begin
            r_skid_d <= i_in_data;
        end
    end

    // -------- front: magnitude and special cases --------
    always_comb begin
        n2_sqx = r1_d.accel_x * r1_d.accel_x;
        n2_sqy = r1_d.accel_y * r1_d.accel_y;
        n2_sqz = r1_d.accel_z * r1_d.accel_z;
        flip   = (r4_d.accel_y > 0) && (CMPW'(r4_lhs) > CMPW'(r4_rhs));
        if (r4_weak) begin
            st4 = gapr_pkg::ST_IDENT;
        end else if (flip) begin
            st4 = gapr_pkg::ST_FLIP;
        end else begin
            st4 = gapr_pkg::ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d   <= src_d;
            r2_d   <= r1_d;
            r2_sqx <= n2_sqx;
            r2_sqy <= n2_sqy;
            r2_sqz <= n2_sqz;
            r3_d   <= r2_d;
            r3_m2  <= M2W'(r2_sqx) + M2W'(r2_sqy) + M2W'(r2_sqz);
            r3_ay2 <= r2_sqy;
            r4_d   <= r3_d;
            r4_m2  <= r3_m2;
            r4_weak <= (r3_m2 == '0) || (r3_m2 < M2W'(r_min_sq));
            r4_lhs <= {r3_ay2, 28'd0};
            r4_rhs <= r_flip_sq * r3_m2;
        end
    end

    // -------- first root chain: |a| with guard bits --------
    assign c1_v[0]      = r4_v;
    assign c1_d[0].rem  = 64'(r4_m2) << (2 * G);
    assign c1_d[0].root = '0;
    assign c1_s[0]      = {st4, r4_d};

    for (genvar k = 0; k < NSQ; k++) begin : g_sq1
        gapr_sqrt_cell #(.STEP(k), .SIDE_W(S1W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c1_v[k]),
            .i_data  (c1_d[k]),
            .i_side  (c1_s[k]),
            .o_valid (c1_v[k+1]),
            .o_data  (c1_d[k+1]),
            .o_side  (c1_s[k+1])
        );
    end

    // -------- unnormalized quaternion and its squared norm --------
    always_comb begin
        s1o     = c1_s[NSQ];
        n_root1 = c1_d[NSQ].root[31:0];
        ayg     = 33'(s1o.d.accel_y) <<< G;
        w33     = $signed({1'b0, n_root1}) - ayg;
        ax_e    = (AW + 1)'(s1o.d.accel_x);
        az_e    = (AW + 1)'(s1o.d.accel_z);
        ax_abs  = (ax_e < 0) ? -ax_e : ax_e;
        az_abs  = (az_e < 0) ? -az_e : az_e;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_st <= s1o.st;
            r6_pt <= '{s1o.d.point_x, s1o.d.point_y, s1o.d.point_z};
            r6_w  <= w33[31:0];
            r6_xm <= 32'(az_abs) << G;
            r6_zm <= 32'(ax_abs) << G;
            r6_sx <= s1o.d.accel_z < 0;
            r6_sz <= s1o.d.accel_x > 0;
            r7_st <= r6_st;
            r7_pt <= r6_pt;
            r7_w  <= r6_w;
            r7_xm <= r6_xm;
            r7_zm <= r6_zm;
            r7_sx <= r6_sx;
            r7_sz <= r6_sz;
            r7_w2 <= r6_w * r6_w;
            r7_x2 <= r6_xm * r6_xm;
            r7_z2 <= r6_zm * r6_zm;
            r8_st <= r7_st;
            r8_pt <= r7_pt;
            r8_w  <= r7_w;
            r8_xm <= r7_xm;
            r8_zm <= r7_zm;
            r8_sx <= r7_sx;
            r8_sz <= r7_sz;
            r8_sum <= r7_w2 + r7_x2 + r7_z2;
        end
    end

    // -------- second root chain: quaternion norm --------
    always_comb begin
        s2i.st = r8_st;
        s2i.sx = r8_sx;
        s2i.sz = r8_sz;
        s2i.w  = r8_w;
        s2i.xm = r8_xm;
        s2i.zm = r8_zm;
        s2i.pt = r8_pt;
    end

    assign c2_v[0]      = r8_v;
    assign c2_d[0].rem  = r8_sum;
    assign c2_d[0].root = '0;
    assign c2_s[0]      = s2i;

    for (genvar k = 0; k < NSQ; k++) begin : g_sq2
        gapr_sqrt_cell #(.STEP(k), .SIDE_W(S2W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c2_v[k]),
            .i_data  (c2_d[k]),
            .i_side  (c2_s[k]),
            .o_valid (c2_v[k+1]),
            .o_data  (c2_d[k+1]),
            .o_side  (c2_s[k+1])
        );
    end

    // -------- dividends, rounded half away from zero --------
    assign s2o = c2_s[NSQ];
    assign qn  = c2_d[NSQ].root[31:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_div     <= (qn == '0) ? 32'd1 : qn;
            r9_dd[0]   <= (DW'(s2o.w) << F) + DW'(qn >> 1);
            r9_dd[1]   <= (DW'(s2o.xm) << F) + DW'(qn >> 1);
            r9_dd[2]   <= (DW'(s2o.zm) << F) + DW'(qn >> 1);
            r9_side.st <= (s2o.st == gapr_pkg::ST_NORMAL && qn == '0) ?
                          gapr_pkg::ST_IDENT : s2o.st;
            r9_side.sx <= s2o.sx;
            r9_side.sz <= s2o.sz;
            r9_side.pt <= s2o.pt;
        end
    end

    assign c3_v[0]   = r9_v;
    assign c3_div[0] = r9_div;
    assign c3_s[0]   = r9_side;
    for (genvar l = 0; l < 3; l++) begin : g_dlane
        assign c3_rem[0][l] = 33'(r9_dd[l] >> (F + 1));
        assign c3_low[0][l] = r9_dd[l][F:0];
        assign c3_quo[0][l] = '0;
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        gapr_div_cell #(.STEP(k), .FB(F), .SIDE_W(S3W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c3_v[k]),
            .i_div   (c3_div[k]),
            .i_rem   (c3_rem[k]),
            .i_low   (c3_low[k]),
            .i_quo   (c3_quo[k]),
            .i_side  (c3_s[k]),
            .o_valid (c3_v[k+1]),
            .o_div   (c3_div[k+1]),
            .o_rem   (c3_rem[k+1]),
            .o_low   (c3_low[k+1]),
            .o_quo   (c3_quo[k+1]),
            .o_side  (c3_s[k+1])
        );
    end

    // -------- quaternion select --------
    always_comb begin
        s3o = c3_s[NDIV];
        ew  = $signed({1'b0, c3_quo[NDIV][0]});
        ex  = $signed({1'b0, c3_quo[NDIV][1]});
        ez  = $signed({1'b0, c3_quo[NDIV][2]});
        unique case (s3o.st)
            gapr_pkg::ST_IDENT: begin
                n10_qw = Q_ONE;
                n10_qx = '0;
                n10_qz = '0;
            end
            gapr_pkg::ST_FLIP: begin
                n10_qw = '0;
                n10_qx = Q_ONE;
                n10_qz = '0;
            end
            default: begin
                n10_qw = ew;
                n10_qx = s3o.sx ? -ex : ex;
                n10_qz = s3o.sz ? -ez : ez;
            end
        endcase
    end

    // -------- rotation matrix and point rotation --------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_st <= s3o.st;
            r10_pt <= s3o.pt;
            r10_qw <= n10_qw;
            r10_qx <= n10_qx;
            r10_qz <= n10_qz;

            r11_st <= r10_st;
            r11_pt <= r10_pt;
            r11_qw <= r10_qw;
            r11_qx <= r10_qx;
            r11_qz <= r10_qz;
            r11_ww <= r10_qw * r10_qw;
            r11_xx <= r10_qx * r10_qx;
            r11_zz <= r10_qz * r10_qz;
            r11_wz <= r10_qw * r10_qz;
            r11_wx <= r10_qw * r10_qx;
            r11_xz <= r10_qx * r10_qz;

            r12_st <= r11_st;
            r12_pt <= r11_pt;
            r12_qw <= r11_qw;
            r12_qx <= r11_qx;
            r12_qz <= r11_qz;
            r12_m[0] <= RW'(r11_ww) + RW'(r11_xx) - RW'(r11_zz);
            r12_m[1] <= -(RW'(r11_wz) <<< 1);
            r12_m[2] <= RW'(r11_xz) <<< 1;
            r12_m[3] <= RW'(r11_wz) <<< 1;
            r12_m[4] <= RW'(r11_ww) - RW'(r11_xx) - RW'(r11_zz);
            r12_m[5] <= -(RW'(r11_wx) <<< 1);
            r12_m[6] <= RW'(r11_xz) <<< 1;
            r12_m[7] <= RW'(r11_wx) <<< 1;
            r12_m[8] <= RW'(r11_ww) - RW'(r11_xx) + RW'(r11_zz);

            r13_st <= r12_st;
            r13_qw <= r12_qw;
            r13_qx <= r12_qx;
            r13_qz <= r12_qz;
            for (int i = 0; i < 3; i++) begin
                r13_p[3*i]   <= r12_m[3*i]   * r12_pt.x;
                r13_p[3*i+1] <= r12_m[3*i+1] * r12_pt.y;
                r13_p[3*i+2] <= r12_m[3*i+2] * r12_pt.z;
            end

            r14_st <= r13_st;
            r14_qw <= r13_qw;
            r14_qx <= r13_qx;
            r14_qz <= r13_qz;
            for (int i = 0; i < 3; i++) begin
                r14_acc[i] <= AW2'(r13_p[3*i]) + AW2'(r13_p[3*i+1]) +
                              AW2'(r13_p[3*i+2]) + HALF;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sh[i] = r14_acc[i] >>> (2 * F);
            if ((&n_sh[i][AW2-1:CW-1]) || !(|n_sh[i][AW2-1:CW-1])) begin
                n_rot[i] = n_sh[i][CW-1:0];
            end else begin
                n_rot[i] = n_sh[i][AW2-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_d.rotated_x    <= n_rot[0];
            r_o_d.rotated_y    <= n_rot[1];
            r_o_d.rotated_z    <= n_rot[2];
            r_o_d.quat_w       <= gapr_pkg::QUAT_W'(r14_qw);
            r_o_d.quat_i       <= gapr_pkg::QUAT_W'(r14_qx);
            r_o_d.quat_j       <= '0;
            r_o_d.quat_k       <= gapr_pkg::QUAT_W'(r14_qz);
            r_o_d.align_status <= r14_st;
        end
    end

    // -------- valid bits --------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r14_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r1_v  <= src_v;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r6_v  <= c1_v[NSQ];
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= c2_v[NSQ];
            r10_v <= c3_v[NDIV];
            r11_v <= r10_v;
            r12_v <= r11_v;
            r13_v <= r12_v;
            r14_v <= r13_v;
            r_o_v <= r14_v;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o_d;

    // -------- checks --------
    a_flip_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.align_status == gapr_pkg::ST_FLIP |->
        o_out_data.quat_w == '0 && o_out_data.quat_k == '0 &&
        o_out_data.quat_i == gapr_pkg::QUAT_W'(Q_ONE))
        else $error("flip beat without half-turn quaternion");

    a_ident_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.align_status == gapr_pkg::ST_IDENT |->
        o_out_data.quat_i == '0 && o_out_data.quat_k == '0 &&
        o_out_data.quat_w == gapr_pkg::QUAT_W'(Q_ONE))
        else $error("identity beat without unit quaternion");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !en |=> r_skid_v && $stable(r_skid_d))
        else $error("skid beat lost while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r14_acc[0]) && $stable(r14_v))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
